@@ rtl/itqn_pkg.sv @@
`timescale 1ns / 1ps
// ============================================================================
// itqn_pkg
// Shared types, constants and the control store of the interval tree
// query sequencer.
// ============================================================================
package itqn_pkg;

    // timestamp and node width
    localparam int unsigned TS_BITS = 16;
    // results per request, including the closing range
    localparam int unsigned MAX_RESULTS = 34;
    // walk results kept before the closing range
    localparam int unsigned MAX_WALK_RESULTS = MAX_RESULTS - 1;
    localparam int unsigned CNT_BITS = $clog2(MAX_RESULTS);

    typedef enum logic [1:0] {
        KIND_LEFT  = 2'd0,
        KIND_RIGHT = 2'd1,
        KIND_ERROR = 2'd2
    } t_kind;

    // program counter of the sequencer
    typedef enum logic [3:0] {
        PC_IDLE    = 4'd0,
        PC_INIT    = 4'd1,
        PC_FORK    = 4'd2,
        PC_SAVE    = 4'd3,
        PC_LOWER   = 4'd4,
        PC_RESTORE = 4'd5,
        PC_UPPER   = 4'd6,
        PC_CLOSE   = 4'd7,
        PC_ERROR   = 4'd8
    } t_pc;

    typedef enum logic [2:0] {
        COND_BAD,        // request interval is unusable
        COND_ROOT_ZERO,  // empty relation
        COND_WALK_DONE,  // current walk has ended
        COND_LO_OUT,     // lower bound beyond the backbone
        COND_HI_OUT,     // upper bound beyond the backbone
        COND_ALWAYS
    } t_cond;

    typedef enum logic [1:0] {
        WALK_NONE,
        WALK_FORK,
        WALK_LOWER,
        WALK_UPPER
    } t_walk;

    typedef enum logic [1:0] {
        LOAD_NONE,
        LOAD_ROOT,     // node = root, step = root / 2
        LOAD_SAVE,     // keep fork node and its step
        LOAD_RESTORE   // node = fork, step = saved step
    } t_load;

    typedef enum logic [1:0] {
        EMIT_NONE,
        EMIT_WALK,
        EMIT_ERROR,
        EMIT_CLOSE
    } t_emit;

    // one control word: jump to jump_pc when cond holds, else stay or fall through
    typedef struct packed {
        t_pc   jump_pc;
        t_cond cond;
        t_walk walk;
        t_load load;
        t_emit emit;
        logic  wait_in;
        logic  stay;
    } t_uword;

    function automatic t_uword ucode(input t_pc pc);
        t_uword w;
        w = '{jump_pc: PC_IDLE, cond: COND_ALWAYS, walk: WALK_NONE,
              load: LOAD_NONE, emit: EMIT_NONE, wait_in: 1'b0, stay: 1'b0};
        unique case (pc)
            PC_IDLE: begin
                w.wait_in = 1'b1;
                w.cond    = COND_BAD;
                w.jump_pc = PC_ERROR;
            end
            PC_INIT: begin
                w.load    = LOAD_ROOT;
                w.cond    = COND_ROOT_ZERO;
                w.jump_pc = PC_CLOSE;
            end
            PC_FORK: begin
                w.walk    = WALK_FORK;
                w.emit    = EMIT_WALK;
                w.cond    = COND_WALK_DONE;
                w.jump_pc = PC_SAVE;
                w.stay    = 1'b1;
            end
            PC_SAVE: begin
                w.load    = LOAD_SAVE;
                w.cond    = COND_LO_OUT;
                w.jump_pc = PC_RESTORE;
            end
            PC_LOWER: begin
                w.walk    = WALK_LOWER;
                w.emit    = EMIT_WALK;
                w.cond    = COND_WALK_DONE;
                w.jump_pc = PC_RESTORE;
                w.stay    = 1'b1;
            end
            PC_RESTORE: begin
                w.load    = LOAD_RESTORE;
                w.cond    = COND_HI_OUT;
                w.jump_pc = PC_CLOSE;
            end
            PC_UPPER: begin
                w.walk    = WALK_UPPER;
                w.emit    = EMIT_WALK;
                w.cond    = COND_WALK_DONE;
                w.jump_pc = PC_CLOSE;
                w.stay    = 1'b1;
            end
            PC_CLOSE: begin
                w.emit    = EMIT_CLOSE;
                w.cond    = COND_ALWAYS;
                w.jump_pc = PC_IDLE;
            end
            PC_ERROR: begin
                w.emit    = EMIT_ERROR;
                w.cond    = COND_ALWAYS;
                w.jump_pc = PC_IDLE;
            end
            default: begin
                w.cond    = COND_ALWAYS;
                w.jump_pc = PC_IDLE;
            end
        endcase
        return w;
    endfunction

    // highest set bit of a 16-bit root, zero stays zero
    function automatic logic [15:0] top_bit(input logic [15:0] v);
        logic [15:0] f;
        f = v;
        f = f | (f >> 1);
        f = f | (f >> 2);
        f = f | (f >> 4);
        f = f | (f >> 8);
        return f ^ (f >> 1);
    endfunction

endpackage

@@ rtl/interval_tree_query_nodes_core.sv @@
`timescale 1ns / 1ps
// ============================================================================
// interval_tree_query_nodes_core
// Query list generator for a relational interval tree over a virtual
// backbone, driven by a small microcoded sequencer.
// ============================================================================
// A request carries an interval (lower, upper). The block walks the virtual
// backbone rooted at the configured tree root (its highest set bit is kept
// at the write) and returns the node query list one result per response:
// left-node ranges and right nodes along the root-to-fork path, left ranges
// along the lower walk, right nodes along the upper walk, then the closing
// range lower..upper flagged with last_result. A lower bound of zero or
// lower above upper gives one error result instead. The sequencer takes one
// walk step per cycle through a single add/subtract unit, except while the
// response side holds back a result. One request is worked at a time; the
// request side is ready only when the sequencer is idle. At most 34 results
// come out per request: walk results past 33 are dropped.
// The root is written through the configuration channel, which is always
// ready and must only be used while the block is idle.
// ============================================================================
module interval_tree_query_nodes_core (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // configuration
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [15:0]                    i_tree_root,
    // request
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic [itqn_pkg::TS_BITS-1:0]   i_lower_bound,
    input  logic [itqn_pkg::TS_BITS-1:0]   i_upper_bound,
    // response
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic [1:0]                     o_query_kind,
    output logic [itqn_pkg::TS_BITS-1:0]   o_range_low,
    output logic [itqn_pkg::TS_BITS-1:0]   o_range_high,
    output logic                           o_last_result
);

    localparam int unsigned TW = itqn_pkg::TS_BITS;
    localparam int unsigned CW = itqn_pkg::CNT_BITS;

    // sequencer state
    itqn_pkg::t_pc       r_pc, n_pc;
    itqn_pkg::t_uword    ctl;

    // root of the backbone, already reduced to its top bit
    logic [15:0]         r_root;

    // request interval
    logic [TW-1:0]       r_lo, r_hi;

    // walk datapath
    logic [TW-1:0]       r_node, r_step;
    logic [TW-1:0]       r_fork, r_saved;
    logic [CW-1:0]       r_count;

    // response register
    logic                r_out_valid;
    itqn_pkg::t_kind     r_kind;
    logic [TW-1:0]       r_rlo, r_rhi;
    logic                r_last;

    // walk decode
    logic                w_done, w_right, w_emit, w_cap, w_step0;
    itqn_pkg::t_kind     w_kind;

    // step control
    logic                cond_hit, need_out, out_free, advance;

    // control word of the current step
    assign ctl = itqn_pkg::ucode(r_pc);

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = ctl.wait_in;

    // ------------------------------------------------------------------
    // walk decode: one comparison set per step, shared by all three walks
    // ------------------------------------------------------------------
    assign w_cap   = (r_count == CW'(itqn_pkg::MAX_WALK_RESULTS));
    assign w_step0 = (r_step == '0);

    always_comb begin
        w_done  = 1'b1;
        w_right = 1'b0;
        w_emit  = 1'b0;
        w_kind  = itqn_pkg::KIND_LEFT;
        unique case (ctl.walk)
            itqn_pkg::WALK_FORK: begin
                // stop at the first node inside the interval or at a leaf
                w_done  = w_step0 || ((r_node >= r_lo) && (r_node <= r_hi));
                w_right = (r_node < r_lo);
                w_emit  = !w_done;
                w_kind  = w_right ? itqn_pkg::KIND_LEFT : itqn_pkg::KIND_RIGHT;
            end
            itqn_pkg::WALK_LOWER: begin
                // nodes passed on the right give left ranges
                w_done  = (r_node == r_lo) || (w_step0 && (r_node > r_lo)) || w_cap;
                w_right = (r_node < r_lo);
                w_emit  = w_right && !w_done;
                w_kind  = itqn_pkg::KIND_LEFT;
            end
            itqn_pkg::WALK_UPPER: begin
                // nodes passed on the left give right nodes
                w_done  = (r_node == r_hi) || (w_step0 && (r_node < r_hi)) || w_cap;
                w_right = !(r_node > r_hi);
                w_emit  = (r_node > r_hi) && !w_done;
                w_kind  = itqn_pkg::KIND_RIGHT;
            end
            default: begin
                w_done  = 1'b1;
                w_right = 1'b0;
                w_emit  = 1'b0;
                w_kind  = itqn_pkg::KIND_LEFT;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // branch condition
    // ------------------------------------------------------------------
    always_comb begin
        unique case (ctl.cond)
            itqn_pkg::COND_BAD:       cond_hit = (i_lower_bound == '0) ||
                                                 (i_lower_bound > i_upper_bound);
            itqn_pkg::COND_ROOT_ZERO: cond_hit = (r_root == '0);
            itqn_pkg::COND_WALK_DONE: cond_hit = w_done;
            // bound at or above twice the root lies outside the backbone
            itqn_pkg::COND_LO_OUT:    cond_hit = ({1'b0, r_lo} >= {r_root, 1'b0});
            itqn_pkg::COND_HI_OUT:    cond_hit = ({1'b0, r_hi} >= {r_root, 1'b0});
            itqn_pkg::COND_ALWAYS:    cond_hit = 1'b1;
            default:                  cond_hit = 1'b1;
        endcase
    end

    // ------------------------------------------------------------------
    // step gating: wait for a request, or for room in the response register
    // ------------------------------------------------------------------
    assign out_free = !r_out_valid || i_out_ready;

    always_comb begin
        unique case (ctl.emit)
            itqn_pkg::EMIT_WALK:  need_out = w_emit;
            itqn_pkg::EMIT_ERROR: need_out = 1'b1;
            itqn_pkg::EMIT_CLOSE: need_out = 1'b1;
            default:              need_out = 1'b0;
        endcase
    end

    assign advance = (!ctl.wait_in || i_in_valid) && (!need_out || out_free);

    // next step
    always_comb begin
        n_pc = r_pc;
        if (advance) begin
            if (cond_hit) begin
                n_pc = ctl.jump_pc;
            end else if (ctl.stay) begin
                n_pc = r_pc;
            end else begin
                n_pc = itqn_pkg::t_pc'(r_pc + 4'd1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= itqn_pkg::PC_IDLE;
        end else begin
            r_pc <= n_pc;
        end
    end

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_root <= '0;
        end else if (i_cfg_valid) begin
            r_root <= itqn_pkg::top_bit(i_tree_root);
        end
    end

    // ------------------------------------------------------------------
    // datapath: request capture, loads and one walk move per step
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (ctl.wait_in && i_in_valid) begin
            r_lo <= i_lower_bound;
            r_hi <= i_upper_bound;
        end
        if (advance) begin
            unique case (ctl.load)
                itqn_pkg::LOAD_ROOT: begin
                    r_node <= TW'(r_root);
                    r_step <= TW'(r_root >> 1);
                end
                itqn_pkg::LOAD_SAVE: begin
                    r_fork  <= r_node;
                    r_saved <= r_step;
                end
                itqn_pkg::LOAD_RESTORE: begin
                    r_node <= r_fork;
                    r_step <= r_saved;
                end
                default: begin
                    if (ctl.walk != itqn_pkg::WALK_NONE && !w_done) begin
                        r_node <= w_right ? (r_node + r_step) : (r_node - r_step);
                        r_step <= r_step >> 1;
                    end
                end
            endcase
        end
    end

    // walk results delivered so far for this request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (ctl.wait_in) begin
            r_count <= '0;
        end else if (advance && ctl.emit == itqn_pkg::EMIT_WALK && w_emit) begin
            r_count <= r_count + CW'(1);
        end
    end

    // ------------------------------------------------------------------
    // response register
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && need_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && need_out) begin
            unique case (ctl.emit)
                itqn_pkg::EMIT_ERROR: begin
                    r_kind <= itqn_pkg::KIND_ERROR;
                    r_rlo  <= '0;
                    r_rhi  <= '0;
                    r_last <= 1'b1;
                end
                itqn_pkg::EMIT_CLOSE: begin
                    r_kind <= itqn_pkg::KIND_LEFT;
                    r_rlo  <= r_lo;
                    r_rhi  <= r_hi;
                    r_last <= 1'b1;
                end
                default: begin
                    r_kind <= w_kind;
                    r_rlo  <= r_node;
                    r_rhi  <= r_node;
                    r_last <= 1'b0;
                end
            endcase
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_query_kind  = r_kind;
    assign o_range_low   = r_rlo;
    assign o_range_high  = r_rhi;
    assign o_last_result = r_last;

endmodule

@@ dv/interval_tree_query_nodes_core_tb.sv @@
`timescale 1ns / 1ps
// ============================================================================
// interval_tree_query_nodes_core_tb
// Self-checking bench for the interval tree query list generator: a directed
// stimulus table followed by random requests under several tree roots and
// idle profiles, with each response checked against an in-bench planner.
// ============================================================================
module interval_tree_query_nodes_core_tb;

    localparam int unsigned TS_BITS     = itqn_pkg::TS_BITS;
    localparam int unsigned MAX_RESULTS = itqn_pkg::MAX_RESULTS;

    // random requests sent per root setting, three root settings per phase
    localparam int unsigned REQS_PER_ROOT = 23;
    localparam int unsigned NUM_DIRECTED  = 24;

    // one expected response
    typedef struct packed {
        itqn_pkg::t_kind    kind;
        logic [TS_BITS-1:0] range_low;
        logic [TS_BITS-1:0] range_high;
        logic               last_result;
    } t_query_result;

    // one row of the directed table; fixed_exp rows carry their single
    // response inline, all others go through the planner
    typedef struct packed {
        logic               set_root;
        logic [15:0]        root;
        logic [TS_BITS-1:0] lower;
        logic [TS_BITS-1:0] upper;
        logic               fixed_exp;
        itqn_pkg::t_kind    kind;
        logic [TS_BITS-1:0] range_low;
        logic [TS_BITS-1:0] range_high;
    } t_stim_row;

    localparam t_stim_row DIRECTED_ROWS [NUM_DIRECTED] = '{
        // empty relation right after reset: only the closing range
        '{1'b0, 16'h0000, 16'd1, 16'd65535, 1'b1, itqn_pkg::KIND_LEFT, 16'd1, 16'd65535},
        // zero lower bound and lower above upper, then a full-width point interval
        '{1'b0, 16'h0000, 16'd0, 16'd0, 1'b1, itqn_pkg::KIND_ERROR, 16'd0, 16'd0},
        '{1'b0, 16'h0000, 16'd5, 16'd4, 1'b1, itqn_pkg::KIND_ERROR, 16'd0, 16'd0},
        '{1'b0, 16'h0000, 16'd65535, 16'd65535, 1'b1, itqn_pkg::KIND_LEFT, 16'd65535,
          16'd65535},
        // smallest backbone, bounds inside and beyond it
        '{1'b1, 16'h0001, 16'd1, 16'd1, 1'b0, itqn_pkg::KIND_LEFT, 16'd0, 16'd0},
        '{1'b0, 16'h0000, 16'd1, 16'd2, 1'b0, itqn_pkg::KIND_LEFT, 16'd0, 16'd0},
        '{1'b0, 16'h0000, 16'd2, 16'd3, 1'b0, itqn_pkg::KIND_LEFT, 16'd0, 16'd0},
        // root that is not a power of two
        '{1'b1, 16'h0006, 16'd3, 16'd5, 1'b0, itqn_pkg::KIND_LEFT, 16'd0, 16'd0},
        '{1'b0, 16'h0000, 16'd1, 16'd7, 1'b0, itqn_pkg::KIND_LEFT, 16'd0, 16'd0},
        '{1'b0, 16'h0000, 16'd7, 16'd7, 1'b0, itqn_pkg::KIND_LEFT, 16'd0, 16'd0},
        // all root bits set, deepest tree
        '{1'b1, 16'hFFFF, 16'd1, 16'd65535, 1'b0, itqn_pkg::KIND_LEFT, 16'd0, 16'd0},
        '{1'b0, 16'h0000, 16'd1, 16'd1, 1'b0, itqn_pkg::KIND_LEFT, 16'd0, 16'd0},
        '{1'b0, 16'h0000, 16'd65535, 16'd65535, 1'b0, itqn_pkg::KIND_LEFT, 16'd0, 16'd0},
        '{1'b0, 16'h0000, 16'd32767, 16'd32769, 1'b0, itqn_pkg::KIND_LEFT, 16'd0, 16'd0},
        '{1'b0, 16'h0000, 16'd0, 16'd65535, 1'b1, itqn_pkg::KIND_ERROR, 16'd0, 16'd0},
        '{1'b0, 16'h0000, 16'd65535, 16'd1, 1'b1, itqn_pkg::KIND_ERROR, 16'd0, 16'd0},
        '{1'b0, 16'h0000, 16'd21845, 16'd43690, 1'b0, itqn_pkg::KIND_LEFT, 16'd0, 16'd0},
        '{1'b0, 16'h0000, 16'd12345, 16'd12346, 1'b0, itqn_pkg::KIND_LEFT, 16'd0, 16'd0},
        // largest power-of-two root
        '{1'b1, 16'h8000, 16'd1, 16'd65534, 1'b0, itqn_pkg::KIND_LEFT, 16'd0, 16'd0},
        '{1'b0, 16'h0000, 16'd32768, 16'd32768, 1'b0, itqn_pkg::KIND_LEFT, 16'd0, 16'd0},
        '{1'b0, 16'h0000, 16'd2, 16'd65533, 1'b0, itqn_pkg::KIND_LEFT, 16'd0, 16'd0},
        // root written back to an empty relation
        '{1'b1, 16'h0000, 16'd3, 16'd9, 1'b1, itqn_pkg::KIND_LEFT, 16'd3, 16'd9},
        '{1'b1, 16'h00FF, 16'd100, 16'd200, 1'b0, itqn_pkg::KIND_LEFT, 16'd0, 16'd0},
        '{1'b0, 16'h0000, 16'd1, 16'd255, 1'b0, itqn_pkg::KIND_LEFT, 16'd0, 16'd0}
    };

    // ------------------------------------------------------------------------
    // block ports
    // ------------------------------------------------------------------------
    logic               i_clk         = 1'b0;
    logic               i_rst_n       = 1'b0;
    logic               i_cfg_valid   = 1'b0;
    logic               o_cfg_ready;
    logic [15:0]        i_tree_root   = '0;
    logic               i_in_valid    = 1'b0;
    logic               o_in_ready;
    logic [TS_BITS-1:0] i_lower_bound = '0;
    logic [TS_BITS-1:0] i_upper_bound = '0;
    logic               o_out_valid;
    logic               i_out_ready   = 1'b0;
    logic [1:0]         o_query_kind;
    logic [TS_BITS-1:0] o_range_low;
    logic [TS_BITS-1:0] o_range_high;
    logic               o_last_result;

    // ------------------------------------------------------------------------
    // bench state
    // ------------------------------------------------------------------------
    t_query_result pending_results [$];  // responses still owed, oldest first
    logic [15:0]   tree_top   = '0;      // highest set bit of the written root
    int unsigned   plan_len;             // walk results planned for this request
    int unsigned   send_idle  = 0;       // percent of cycles the request side idles
    int unsigned   recv_idle  = 0;       // percent of cycles the response side stalls
    int unsigned   mismatches = 0;

    interval_tree_query_nodes_core u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_tree_root   (i_tree_root),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_lower_bound (i_lower_bound),
        .i_upper_bound (i_upper_bound),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_query_kind  (o_query_kind),
        .o_range_low   (o_range_low),
        .o_range_high  (o_range_high),
        .o_last_result (o_last_result)
    );

    // 12 ns clock
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // query planner
    // ------------------------------------------------------------------------

    // one walk result, dropped once the list is full
    function automatic void note_node(input itqn_pkg::t_kind node_kind,
                                      input logic [63:0] node);
        if (plan_len < MAX_RESULTS) begin
            pending_results.push_back('{kind: node_kind, range_low: node[TS_BITS-1:0],
                                        range_high: node[TS_BITS-1:0], last_result: 1'b0});
            plan_len++;
        end
    endfunction

    // appends the full query list of one request to pending_results
    function automatic void plan_query(input logic [TS_BITS-1:0] lower,
                                       input logic [TS_BITS-1:0] upper);
        logic [63:0] lo, hi, top, node, step, fork_node, saved_step;
        int          k;
        lo       = 64'(lower);
        hi       = 64'(upper);
        top      = 64'(tree_top);
        plan_len = 0;

        // unusable interval: one error result and nothing else
        if (lo == 0 || lo > hi) begin
            pending_results.push_back('{kind: itqn_pkg::KIND_ERROR, range_low: '0,
                                        range_high: '0, last_result: 1'b1});
            return;
        end

        if (top != 0) begin
            // halving search for the first node inside the interval
            node = top;
            step = top >> 1;
            while (step >= 1) begin
                if (hi < node)
                    node -= step;
                else if (node < lo)
                    node += step;
                else
                    break;
                step >>= 1;
            end
            fork_node = node;

            // root to fork: passed on the right gives a left range, else a right node
            node = top;
            step = top >> 1;
            for (k = 0; node != fork_node && k < 64; k++) begin
                if (node < fork_node) begin
                    note_node(itqn_pkg::KIND_LEFT, node);
                    node += step;
                end else begin
                    note_node(itqn_pkg::KIND_RIGHT, node);
                    node -= step;
                end
                step >>= 1;
            end
            saved_step = step;

            // fork down to the lower bound, skipped when it lies past the backbone
            if (lo < 2 * top) begin
                for (k = 0; node != lo && k < 64; k++) begin
                    if (node < lo) begin
                        note_node(itqn_pkg::KIND_LEFT, node);
                        node += step;
                    end else begin
                        node -= step;
                    end
                    step >>= 1;
                end
            end

            // fork down to the upper bound
            step = saved_step;
            node = fork_node;
            if (hi < 2 * top) begin
                for (k = 0; node != hi && k < 64; k++) begin
                    if (node > hi) begin
                        note_node(itqn_pkg::KIND_RIGHT, node);
                        node -= step;
                    end else begin
                        node += step;
                    end
                    step >>= 1;
                end
            end
        end

        // the closing range always fits: it replaces the last walk result if full
        if (plan_len >= MAX_RESULTS)
            void'(pending_results.pop_back());
        pending_results.push_back('{kind: itqn_pkg::KIND_LEFT, range_low: lower,
                                    range_high: upper, last_result: 1'b1});
    endfunction

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------

    task automatic report_mismatch(input string msg);
        $display("%0t ns  mismatch: %s", $time, msg);
        mismatches++;
    endtask

    // present one request, returns at the edge where it is taken
    task automatic send_request(input logic [TS_BITS-1:0] lower,
                                input logic [TS_BITS-1:0] upper);
        @(negedge i_clk);
        while ($urandom_range(0, 99) < send_idle) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_in_valid    = 1'b1;
        i_lower_bound = lower;
        i_upper_bound = upper;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    // root write, only once the block has drained every response
    task automatic set_tree_root(input logic [15:0] root);
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (pending_results.size() != 0)
            @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_tree_root = root;
        do @(posedge i_clk); while (!o_cfg_ready);
        // the block keeps only the highest set bit of the root
        tree_top = '0;
        for (int i = 0; i < 16; i++)
            if (root[i])
                tree_top = 16'(1) << i;
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    // mix of powers of two, arbitrary patterns, tiny trees and the extremes
    function automatic logic [15:0] pick_root();
        case ($urandom_range(0, 3))
            0:       return 16'(1) << $urandom_range(0, 15);
            1:       return 16'($urandom_range(0, 65535));
            2:       return 16'(1) << $urandom_range(0, 4);
            default: return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // response side: random stall, check every accepted response
    // ------------------------------------------------------------------------
    always @(negedge i_clk)
        i_out_ready <= ($urandom_range(0, 99) >= recv_idle);

    always @(posedge i_clk) begin : check_results
        t_query_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_results.size() == 0) begin
                report_mismatch($sformatf("response with no request pending: kind %0d %0d..%0d",
                                          o_query_kind, o_range_low, o_range_high));
            end else begin
                want = pending_results.pop_front();
                if (o_query_kind !== want.kind)
                    report_mismatch($sformatf("query_kind %0d, expected %0d",
                                              o_query_kind, want.kind));
                if (o_range_low !== want.range_low)
                    report_mismatch($sformatf("range_low %0d, expected %0d",
                                              o_range_low, want.range_low));
                if (o_range_high !== want.range_high)
                    report_mismatch($sformatf("range_high %0d, expected %0d",
                                              o_range_high, want.range_high));
                if (o_last_result !== want.last_result)
                    report_mismatch($sformatf("last_result %0d, expected %0d",
                                              o_last_result, want.last_result));
            end
        end
    end

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial begin : run
        int unsigned lo_pick, hi_pick, span_top, narrow, pick;
        t_stim_row   row;

        // synchronous reset first, the root comes up as an empty relation
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed table, run under the first idle profile
        send_idle = 31;
        recv_idle = 83;
        for (int r = 0; r < NUM_DIRECTED; r++) begin
            row = DIRECTED_ROWS[r];
            if (row.set_root)
                set_tree_root(row.root);
            send_request(row.lower, row.upper);
            if (row.fixed_exp)
                pending_results.push_back('{kind: row.kind, range_low: row.range_low,
                                            range_high: row.range_high, last_result: 1'b1});
            else
                plan_query(row.lower, row.upper);
        end

        // random phases: sender idles lightly while the receiver stalls heavily,
        // then the other way round, then both sides run flat out
        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin send_idle = 31; recv_idle = 83; end
                1: begin send_idle = 83; recv_idle = 31; end
                default: begin send_idle = 0; recv_idle = 0; end
            endcase
            for (int blk = 0; blk < 3; blk++) begin
                set_tree_root(pick_root());
                repeat (REQS_PER_ROOT) begin
                    pick = $urandom_range(0, 99);
                    if (pick < 5) begin
                        // zero lower bound
                        lo_pick = 0;
                        hi_pick = $urandom_range(0, 65535);
                    end else if (pick < 10) begin
                        // lower above upper
                        hi_pick = $urandom_range(0, 65534);
                        lo_pick = $urandom_range(hi_pick + 1, 65535);
                    end else if (pick < 75 && tree_top != 0) begin
                        // both bounds inside the backbone, wide or narrow
                        span_top = 2 * int'(tree_top) - 1;
                        lo_pick  = $urandom_range(1, span_top);
                        if ($urandom_range(0, 1)) begin
                            hi_pick = $urandom_range(lo_pick, span_top);
                        end else begin
                            narrow  = lo_pick + $urandom_range(0, 7);
                            hi_pick = (narrow > span_top) ? span_top : narrow;
                        end
                    end else begin
                        // anywhere in the timestamp range, often past the backbone
                        lo_pick = $urandom_range(1, 65535);
                        hi_pick = $urandom_range(lo_pick, 65535);
                    end
                    send_request(TS_BITS'(lo_pick), TS_BITS'(hi_pick));
                    plan_query(TS_BITS'(lo_pick), TS_BITS'(hi_pick));
                end
            end
        end

        // drain, then give the block a little longer than one worst request
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (64) @(posedge i_clk);

        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // watchdog: several times the slowest legal run
    initial begin : watchdog
        #12_000_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/itqn_pkg.sv
rtl/interval_tree_query_nodes_core.sv
dv/interval_tree_query_nodes_core_tb.sv
